[hdl/bsd_pkg.sv]
package bsd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 512;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int LINE_W = $clog2(MAX_HEIGHT);
  localparam int BANK_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int BG_DEPTH   = 2 * BANK_DEPTH;
  localparam int BG_ADDR_W  = 1 + LINE_W + COL_W;

  localparam int PIX_W   = 8;
  localparam int DIFF_W  = 10;
  localparam int COUNT_W = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration field widths.
  localparam int FW_W  = 11;
  localparam int FH_W  = 10;
  localparam int WX_W  = 12;
  localparam int WY_W  = 11;
  localparam int THR_W = 10;
  localparam int UT_W  = 21;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
  localparam int IQ_CNT_W = IQ_PTR_W + 1;

  typedef enum logic {
    OP_DETECT = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH      = 3'd0,
    REG_FRAME_HEIGHT     = 3'd1,
    REG_WINDOW_LEFT      = 3'd2,
    REG_WINDOW_TOP       = 3'd3,
    REG_WINDOW_RIGHT     = 3'd4,
    REG_WINDOW_BOTTOM    = 3'd5,
    REG_DIFF_THRESHOLD   = 3'd6,
    REG_UPDATE_THRESHOLD = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [FW_W-1:0]        frame_width;
    logic [FH_W-1:0]        frame_height;
    logic signed [WX_W-1:0] window_left;
    logic signed [WY_W-1:0] window_top;
    logic signed [WX_W-1:0] window_right;
    logic signed [WY_W-1:0] window_bottom;
  } geom_cfg_t;

  typedef struct packed {
    op_t                op;
    logic [PIX_W-1:0]   pixel;
    logic [COL_W-1:0]   col;
    logic [LINE_W-1:0]  line;
    logic               in_window;
    logic               frame_end;
  } item_t;

  typedef struct packed {
    logic               detected;
    logic [COUNT_W-1:0] bright_count;
    logic [COL_W-1:0]   best_x;
    logic [LINE_W-1:0]  best_y;
    logic               background_replaced;
  } result_t;

endpackage

[hdl/bright_spot_detector.sv]
// Throughput: one pixel per clock while the item queue is not full; the background
// RAM takes one read and one write per cycle, which sets the rate.
// The result of a frame is shown on the result ports once its last pixel has passed
// the item queue, the RAM read, the compare stage and the result queue.
// Reset clears the raster position, counters, peak, bank select and queues and
// loads the register defaults; the background RAM is not cleared.
module bright_spot_detector import bsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  operation,
  input  logic [PIX_W-1:0]      pixel,
  output logic                  empty,
  input  logic                  pop,
  output logic                  detected,
  output logic [COUNT_W-1:0]    bright_count,
  output logic [COL_W-1:0]      best_x,
  output logic [LINE_W-1:0]     best_y,
  output logic                  background_replaced,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  geom_cfg_t              geom;
  logic signed [THR_W-1:0] diff_threshold;
  logic signed [UT_W-1:0]  update_threshold;

  logic    accept, q_valid, q_pop;
  item_t   f_item, q_item;
  result_t res;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.frame_width   <= FW_W'(640);
      geom.frame_height  <= FH_W'(480);
      geom.window_left   <= '0;
      geom.window_top    <= '0;
      geom.window_right  <= '1;
      geom.window_bottom <= '1;
      diff_threshold     <= THR_W'(50);
      update_threshold   <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:      geom.frame_width   <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT:     geom.frame_height  <= cfg_data[FH_W-1:0];
        REG_WINDOW_LEFT:      geom.window_left   <= cfg_data[WX_W-1:0];
        REG_WINDOW_TOP:       geom.window_top    <= cfg_data[WY_W-1:0];
        REG_WINDOW_RIGHT:     geom.window_right  <= cfg_data[WX_W-1:0];
        REG_WINDOW_BOTTOM:    geom.window_bottom <= cfg_data[WY_W-1:0];
        REG_DIFF_THRESHOLD:   diff_threshold     <= cfg_data[THR_W-1:0];
        REG_UPDATE_THRESHOLD: update_threshold   <= cfg_data[UT_W-1:0];
        default: ;
      endcase
    end
  end

  bsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (geom),
    .accept   (accept),
    .operation(operation),
    .pixel    (pixel),
    .item     (f_item)
  );

  bsd_item_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (accept),
    .wr_item(f_item),
    .full   (full),
    .rd     (q_pop),
    .valid  (q_valid),
    .rd_item(q_item)
  );

  bsd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .diff_threshold  (diff_threshold),
    .update_threshold(update_threshold),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .res             (res)
  );

  assign detected            = res.detected;
  assign bright_count        = res.bright_count;
  assign best_x              = res.best_x;
  assign best_y              = res.best_y;
  assign background_replaced = res.background_replaced;

  a_detected_matches_count: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (detected == (bright_count != '0)))
    else $error("detected flag disagrees with the bright count");

  a_full_means_queued: assert property (@(posedge clk) disable iff (rst)
    full |-> q_valid)
    else $error("item queue reports full with no item at its head");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("back part took a beat from an empty item queue");

endmodule

[hdl/bsd_ram.sv]
module bsd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/bsd_front.sv]
module bsd_front import bsd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  geom_cfg_t        cfg,
  input  logic             accept,
  input  logic             operation,
  input  logic [PIX_W-1:0] pixel,
  output item_t            item
);

  logic [COL_W-1:0]  col, col_next;
  logic [LINE_W-1:0] line, line_next;
  logic [FW_W-1:0]   w, l, r, col_ext;
  logic [FH_W-1:0]   h, t, b, line_ext;
  logic              col_wrap, line_wrap;

  always_comb begin
    // Out-of-range frame sizes are clamped to one and to the maximum.
    if (cfg.frame_width == '0) begin
      w = FW_W'(1);
    end else if (cfg.frame_width > FW_W'(MAX_WIDTH)) begin
      w = FW_W'(MAX_WIDTH);
    end else begin
      w = cfg.frame_width;
    end
    if (cfg.frame_height == '0) begin
      h = FH_W'(1);
    end else if (cfg.frame_height > FH_W'(MAX_HEIGHT)) begin
      h = FH_W'(MAX_HEIGHT);
    end else begin
      h = cfg.frame_height;
    end

    // Window bounds outside the frame fall back to the frame edges.
    l = (cfg.window_left[WX_W-1] || (cfg.window_left[FW_W-1:0] > w)) ?
        '0 : cfg.window_left[FW_W-1:0];
    r = (cfg.window_right[WX_W-1] || (cfg.window_right[FW_W-1:0] > w)) ?
        w : cfg.window_right[FW_W-1:0];
    t = (cfg.window_top[WY_W-1] || (cfg.window_top[FH_W-1:0] > h)) ?
        '0 : cfg.window_top[FH_W-1:0];
    b = (cfg.window_bottom[WY_W-1] || (cfg.window_bottom[FH_W-1:0] > h)) ?
        h : cfg.window_bottom[FH_W-1:0];

    col_ext  = FW_W'(col);
    line_ext = FH_W'(line);

    col_wrap  = (col_ext + FW_W'(1)) >= w;
    line_wrap = (line_ext + FH_W'(1)) >= h;

    col_next  = col_wrap ? '0 : col + COL_W'(1);
    line_next = line;
    if (col_wrap) begin
      line_next = line_wrap ? '0 : line + LINE_W'(1);
    end

    item.op        = op_t'(operation);
    item.pixel     = pixel;
    item.col       = col;
    item.line      = line;
    item.in_window = (col_ext >= l) && (col_ext < r) && (line_ext >= t) && (line_ext < b);
    item.frame_end = col_wrap && line_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      line <= '0;
    end else if (accept) begin
      col  <= col_next;
      line <= line_next;
    end
  end

endmodule

[hdl/bsd_item_queue.sv]
module bsd_item_queue import bsd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd,
  output logic  valid,
  output item_t rd_item
);

  item_t               slots [IQ_DEPTH];
  logic [IQ_PTR_W-1:0] wptr, rptr;
  logic [IQ_CNT_W-1:0] count;

  assign full    = (count == IQ_CNT_W'(IQ_DEPTH));
  assign valid   = (count != '0);
  assign rd_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + IQ_PTR_W'(1);
      end
      if (rd) begin
        rptr <= rptr + IQ_PTR_W'(1);
      end
      case ({wr, rd})
        2'b10:   count <= count + IQ_CNT_W'(1);
        2'b01:   count <= count - IQ_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/bsd_back.sv]
module bsd_back import bsd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [THR_W-1:0]  diff_threshold,
  input  logic signed [UT_W-1:0]   update_threshold,
  input  logic                     q_valid,
  input  item_t                    q_item,
  output logic                     q_pop,
  input  logic                     pop,
  output logic                     empty,
  output result_t                  res
);

  // Compare stage: the item whose background beat is in rdata.
  logic                     b_valid;
  item_t                    b_item;
  logic [PIX_W-1:0]         rdata;

  logic                     bank, bank_eff;
  logic [COUNT_W-1:0]       hit_count, hit_inc, cnt_new;
  logic signed [DIFF_W-1:0] peak_diff, diff;
  logic [COL_W-1:0]         peak_column, peak_col_new;
  logic [LINE_W-1:0]        peak_line, peak_line_new;

  logic pass, raise, ge0, ge1, repl, b_result, b_adv, issue;

  // Two-entry result queue.
  result_t    rq [2];
  logic       rq_wptr, rq_rptr;
  logic [1:0] rq_count;
  logic       rq_full, rq_push, rq_pop;
  result_t    rq_in;

  logic                 we;
  logic [BG_ADDR_W-1:0] waddr, raddr;

  always_comb begin
    diff  = $signed({2'b00, b_item.pixel}) - $signed({2'b00, rdata});
    pass  = (b_item.op == OP_DETECT) && b_item.in_window && (diff >= diff_threshold);
    raise = pass && (diff > peak_diff);

    hit_inc = (hit_count == COUNT_MAX) ? hit_count : hit_count + COUNT_W'(1);
    cnt_new = pass ? hit_inc : hit_count;

    // Both outcomes of the count compare come from registers only, so the
    // bank decision is a select on pass.
    ge0  = {1'b0, hit_count} >= update_threshold[UT_W-1:0];
    ge1  = {1'b0, hit_inc} >= update_threshold[UT_W-1:0];
    repl = !update_threshold[UT_W-1] && (pass ? ge1 : ge0);

    peak_col_new  = raise ? b_item.col : peak_column;
    peak_line_new = raise ? b_item.line : peak_line;

    b_result = b_item.frame_end && (b_item.op == OP_DETECT);
    b_adv    = b_valid && !(b_result && rq_full);
    issue    = q_valid && (!b_valid || b_adv);
    q_pop    = issue;

    // A swap decided by the retiring frame end already applies to the item
    // issued in the same cycle.
    bank_eff = (b_adv && b_result && repl) ? ~bank : bank;

    raddr = {bank_eff, q_item.line, q_item.col};
    we    = issue;
    waddr = {(q_item.op == OP_LOAD) ? bank_eff : ~bank_eff, q_item.line, q_item.col};

    rq_in.detected            = (cnt_new != '0);
    rq_in.bright_count        = cnt_new;
    rq_in.best_x              = peak_col_new;
    rq_in.best_y              = peak_line_new;
    rq_in.background_replaced = repl;

    rq_push = b_adv && b_result;
    rq_pop  = pop && (rq_count != '0);
    rq_full = (rq_count == 2'd2);
    empty   = (rq_count == '0);
    res     = rq[rq_rptr];
  end

  bsd_ram #(
    .DATA_W(PIX_W),
    .DEPTH (BG_DEPTH)
  ) u_bg_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(q_item.pixel),
    .re   (issue),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (issue) begin
      b_item <= q_item;
    end
    if (rq_push) begin
      rq[rq_wptr] <= rq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid     <= 1'b0;
      bank        <= 1'b0;
      hit_count   <= '0;
      peak_diff   <= '1;
      peak_column <= '0;
      peak_line   <= '0;
      rq_wptr     <= 1'b0;
      rq_rptr     <= 1'b0;
      rq_count    <= '0;
    end else begin
      if (issue) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      bank <= bank_eff;
      if (b_adv) begin
        peak_column <= peak_col_new;
        peak_line   <= peak_line_new;
        if (b_item.frame_end) begin
          hit_count <= '0;
          peak_diff <= '1;
        end else begin
          hit_count <= cnt_new;
          if (raise) begin
            peak_diff <= diff;
          end
        end
      end
      if (rq_push) begin
        rq_wptr <= ~rq_wptr;
      end
      if (rq_pop) begin
        rq_rptr <= ~rq_rptr;
      end
      case ({rq_push, rq_pop})
        2'b10:   rq_count <= rq_count + 2'd1;
        2'b01:   rq_count <= rq_count - 2'd1;
        default: rq_count <= rq_count;
      endcase
    end
  end

endmodule
